// ===== rtl/midpoint_ellipse_generator_assert.svh =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_generator_assert.svh
// Assertion macros shared by the ellipse generator modules. Each macro
// samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_GENERATOR_ASSERT_SVH
`define MIDPOINT_ELLIPSE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define MEG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MEG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/meg_pkg.sv =====
// ----------------------------------------------------------------------------
// meg_pkg
// Shared types and constants of the midpoint ellipse generator: controller
// commands, datapath status, multiplier operand selects, register indexes.
// ----------------------------------------------------------------------------
package meg_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int RADIUS_BITS_DEF = 12;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS_X = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS_Y = 2'd3;

    typedef enum logic [2:0] {
        MUL_RXRX,
        MUL_RYRY,
        MUL_RX2RY,
        MUL_TT,
        MUL_YY,
        MUL_RY2TMP,
        MUL_RX2TMP,
        MUL_RX2RY2
    } mul_sel_t;

    typedef struct packed {
        logic     latch_cfg;
        mul_sel_t mul_sel;
        logic     load_rx2;
        logic     load_ry2;
        logic     init_trace;
        logic     emit;
        logic     load_tmp;
        logic     dec_load;
        logic     dec_add;
        logic     dec_sub;
    } meg_cmd_t;

    typedef struct packed {
        logic out_free;
        logic trans;
    } meg_status_t;

endpackage

// ===== rtl/midpoint_ellipse_generator.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_generator
// Midpoint ellipse rasterizer: one quadrant point per input request.
// ----------------------------------------------------------------------------
// An advance request (restart low) goes from acceptance straight to the emit
// state; a restart request first passes through states S_R0 to S_R3, where the
// squared radii and the rx^2*ry product pass one at a time through the single
// shared multiplier. The emit waits until the output register is free. The step
// that moves the trace from region 1 to region 2 then passes through states S_T0
// to S_T5 before the next request is taken, while the region 2 decision is rebuilt
// by five products on that same multiplier. No new request is taken until the
// previous one has been emitted. A finished result waits in the output
// register while the next request is accepted. Center and radii are latched at
// restart; writes to them take effect at the next restart.
// ----------------------------------------------------------------------------
module midpoint_ellipse_generator
    import meg_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int CFG_W       = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         restart,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         point_valid,
    output logic                         point_last,
    output logic signed [COORD_BITS:0]   x_plus,
    output logic signed [COORD_BITS:0]   x_minus,
    output logic signed [COORD_BITS:0]   y_plus,
    output logic signed [COORD_BITS:0]   y_minus
);

    meg_cmd_t    cmd;
    meg_status_t sts;

    meg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .restart  (restart),
        .sts      (sts),
        .cmd      (cmd)
    );

    meg_datapath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .CFG_W       (CFG_W)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_valid (point_valid),
        .point_last  (point_last),
        .x_plus      (x_plus),
        .x_minus     (x_minus),
        .y_plus      (y_plus),
        .y_minus     (y_minus)
    );

endmodule

// ===== rtl/meg_datapath.sv =====
// ----------------------------------------------------------------------------
// meg_datapath
// Configuration registers, trace state, shared multiplier and the output
// register of the ellipse generator. Driven by meg_ctrl commands.
// ----------------------------------------------------------------------------
module meg_datapath
    import meg_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int CFG_W       = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  meg_cmd_t                     cmd,
    output meg_status_t                  sts,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         point_valid,
    output logic                         point_last,
    output logic signed [COORD_BITS:0]   x_plus,
    output logic signed [COORD_BITS:0]   x_minus,
    output logic signed [COORD_BITS:0]   y_plus,
    output logic signed [COORD_BITS:0]   y_minus
);

    localparam int OFS_W  = RADIUS_BITS + 2;
    localparam int STEP_W = 3 * RADIUS_BITS + 4;
    localparam int DEC_W  = 3 * RADIUS_BITS + 8;
    localparam int SQ_W   = 2 * RADIUS_BITS;
    localparam int MA_W   = 2 * RADIUS_BITS;
    localparam int MB_W   = 2 * RADIUS_BITS + 6;
    localparam int OUT_W  = COORD_BITS + 1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_REG1,
        PH_REG2,
        PH_DONE
    } phase_t;

    logic signed [COORD_BITS-1:0]  cx_cfg_reg;
    logic signed [COORD_BITS-1:0]  cy_cfg_reg;
    logic [RADIUS_BITS-1:0]        rx_cfg_reg;
    logic [RADIUS_BITS-1:0]        ry_cfg_reg;

    logic signed [COORD_BITS-1:0]  lat_cx_reg;
    logic signed [COORD_BITS-1:0]  lat_cy_reg;
    logic [RADIUS_BITS-1:0]        lat_rx_reg;
    logic [RADIUS_BITS-1:0]        lat_ry_reg;
    logic [SQ_W-1:0]               rx2_reg;
    logic [SQ_W-1:0]               ry2_reg;
    logic [MB_W-1:0]               tmp_reg;
    logic [DEC_W-1:0]              prod_reg;

    logic signed [OFS_W-1:0]       offset_x_reg;
    logic signed [OFS_W-1:0]       offset_y_reg;
    logic [STEP_W-1:0]             step_x_reg;
    logic [STEP_W-1:0]             step_y_reg;
    logic [DEC_W-1:0]              decision_reg;
    phase_t                        phase_reg;

    logic                          out_valid_reg;
    logic                          point_valid_reg;
    logic                          point_last_reg;
    logic signed [OUT_W-1:0]       x_plus_reg;
    logic signed [OUT_W-1:0]       x_minus_reg;
    logic signed [OUT_W-1:0]       y_plus_reg;
    logic signed [OUT_W-1:0]       y_minus_reg;

    logic [MA_W-1:0]               mul_a;
    logic [MB_W-1:0]               mul_b;
    logic [MA_W+MB_W-1:0]          mul_full;

    logic [OFS_W:0]                t_val;
    logic signed [OFS_W-1:0]       ym1;
    logic [OFS_W-1:0]              ym1_mag;

    logic [STEP_W-1:0]             ry2_x2;
    logic [STEP_W-1:0]             rx2_x2;
    logic [STEP_W-1:0]             nsx1;
    logic [STEP_W-1:0]             nsy1;
    logic [DEC_W-1:0]              ry2_d4;
    logic [DEC_W-1:0]              rx2_d4;
    logic [DEC_W-1:0]              nsx1_d4;
    logic [DEC_W-1:0]              nsy1_d4;
    logic                          d_neg;
    logic                          d_pos;

    logic signed [OFS_W-1:0]       offset_x_next;
    logic signed [OFS_W-1:0]       offset_y_next;
    logic [STEP_W-1:0]             step_x_next;
    logic [STEP_W-1:0]             step_y_next;
    logic [DEC_W-1:0]              decision_next;
    phase_t                        phase_next;
    logic                          trans;

    logic                          active;
    logic                          out_free;
    logic signed [OUT_W-1:0]       cx_out;
    logic signed [OUT_W-1:0]       cy_out;
    logic signed [OUT_W-1:0]       x_out;
    logic signed [OUT_W-1:0]       y_out;

    // multiplier operands
    assign t_val   = {offset_x_reg, 1'b1};
    assign ym1     = offset_y_reg - OFS_W'(1);
    assign ym1_mag = ym1[OFS_W-1] ? (~ym1 + OFS_W'(1)) : ym1;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_RXRX:
            begin
                mul_a = MA_W'(lat_rx_reg);
                mul_b = MB_W'(lat_rx_reg);
            end
            MUL_RYRY:
            begin
                mul_a = MA_W'(lat_ry_reg);
                mul_b = MB_W'(lat_ry_reg);
            end
            MUL_RX2RY:
            begin
                mul_a = MA_W'(rx2_reg);
                mul_b = MB_W'(lat_ry_reg);
            end
            MUL_TT:
            begin
                mul_a = MA_W'(t_val);
                mul_b = MB_W'(t_val);
            end
            MUL_YY:
            begin
                mul_a = MA_W'(ym1_mag);
                mul_b = MB_W'(ym1_mag);
            end
            MUL_RY2TMP:
            begin
                mul_a = MA_W'(ry2_reg);
                mul_b = tmp_reg;
            end
            MUL_RX2TMP:
            begin
                mul_a = MA_W'(rx2_reg);
                mul_b = tmp_reg;
            end
            MUL_RX2RY2:
            begin
                mul_a = MA_W'(rx2_reg);
                mul_b = MB_W'(ry2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // trace step terms
    assign ry2_x2  = STEP_W'(ry2_reg) << 1;
    assign rx2_x2  = STEP_W'(rx2_reg) << 1;
    assign nsx1    = step_x_reg + ry2_x2;
    assign nsy1    = step_y_reg - rx2_x2;
    assign ry2_d4  = DEC_W'(ry2_reg) << 2;
    assign rx2_d4  = DEC_W'(rx2_reg) << 2;
    assign nsx1_d4 = DEC_W'($signed(nsx1)) << 2;
    assign nsy1_d4 = DEC_W'($signed(nsy1)) << 2;
    assign d_neg   = decision_reg[DEC_W-1];
    assign d_pos   = !d_neg && (|decision_reg);

    always_comb
    begin
        offset_x_next = offset_x_reg;
        offset_y_next = offset_y_reg;
        step_x_next   = step_x_reg;
        step_y_next   = step_y_reg;
        decision_next = decision_reg;
        phase_next    = phase_reg;
        trans         = 1'b0;
        case (phase_reg)
            PH_REG1:
            begin
                offset_x_next = offset_x_reg + OFS_W'(1);
                step_x_next   = nsx1;
                if (d_neg)
                begin
                    decision_next = decision_reg + nsx1_d4 + ry2_d4;
                end
                else
                begin
                    offset_y_next = offset_y_reg - OFS_W'(1);
                    step_y_next   = nsy1;
                    decision_next = decision_reg + nsx1_d4 - nsy1_d4 + ry2_d4;
                end
                trans = !($signed(step_x_next) < $signed(step_y_next));
                if (trans)
                begin
                    phase_next = PH_REG2;
                end
            end
            PH_REG2:
            begin
                offset_y_next = offset_y_reg - OFS_W'(1);
                step_y_next   = nsy1;
                if (d_pos)
                begin
                    decision_next = decision_reg + rx2_d4 - nsy1_d4;
                end
                else
                begin
                    offset_x_next = offset_x_reg + OFS_W'(1);
                    step_x_next   = nsx1;
                    decision_next = decision_reg + nsx1_d4 - nsy1_d4 + rx2_d4;
                end
                if (offset_y_next[OFS_W-1])
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign active   = (phase_reg == PH_REG1) || (phase_reg == PH_REG2);
    assign out_free = !out_valid_reg || out_ready;
    assign cx_out   = OUT_W'(lat_cx_reg);
    assign cy_out   = OUT_W'(lat_cy_reg);
    assign x_out    = OUT_W'(offset_x_reg);
    assign y_out    = OUT_W'(offset_y_reg);

    assign sts.out_free = out_free;
    assign sts.trans    = trans;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_cfg_reg <= '0;
            cy_cfg_reg <= '0;
            rx_cfg_reg <= '0;
            ry_cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_X: cx_cfg_reg <= cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Y: cy_cfg_reg <= cfg_data[COORD_BITS-1:0];
                CFG_RADIUS_X: rx_cfg_reg <= cfg_data[RADIUS_BITS-1:0];
                CFG_RADIUS_Y: ry_cfg_reg <= cfg_data[RADIUS_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init_trace)
            begin
                phase_reg <= PH_REG1;
            end
            else if (cmd.emit)
            begin
                phase_reg <= phase_next;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and arithmetic state
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[DEC_W-1:0];
        if (cmd.latch_cfg)
        begin
            lat_cx_reg <= cx_cfg_reg;
            lat_cy_reg <= cy_cfg_reg;
            lat_rx_reg <= rx_cfg_reg;
            lat_ry_reg <= ry_cfg_reg;
        end
        if (cmd.load_rx2)
        begin
            rx2_reg <= prod_reg[SQ_W-1:0];
        end
        if (cmd.load_ry2)
        begin
            ry2_reg <= prod_reg[SQ_W-1:0];
        end
        if (cmd.load_tmp)
        begin
            tmp_reg <= prod_reg[MB_W-1:0];
        end

        if (cmd.init_trace)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= OFS_W'(lat_ry_reg);
            step_x_reg   <= '0;
            step_y_reg   <= STEP_W'(prod_reg) << 1;
            decision_reg <= ry2_d4 - (prod_reg << 2) + DEC_W'(rx2_reg);
        end
        else if (cmd.emit)
        begin
            offset_x_reg <= offset_x_next;
            offset_y_reg <= offset_y_next;
            step_x_reg   <= step_x_next;
            step_y_reg   <= step_y_next;
            decision_reg <= decision_next;
        end
        else if (cmd.dec_load)
        begin
            decision_reg <= prod_reg;
        end
        else if (cmd.dec_add)
        begin
            decision_reg <= decision_reg + (prod_reg << 2);
        end
        else if (cmd.dec_sub)
        begin
            decision_reg <= decision_reg - (prod_reg << 2);
        end

        if (cmd.emit)
        begin
            if (active)
            begin
                point_valid_reg <= 1'b1;
                point_last_reg  <= (phase_reg == PH_REG2) &&
                                   (offset_y_reg[OFS_W-1] || (offset_y_reg == '0));
                x_plus_reg      <= cx_out + x_out;
                x_minus_reg     <= cx_out - x_out;
                y_plus_reg      <= cy_out + y_out;
                y_minus_reg     <= cy_out - y_out;
            end
            else
            begin
                point_valid_reg <= 1'b0;
                point_last_reg  <= 1'b0;
                x_plus_reg      <= '0;
                x_minus_reg     <= '0;
                y_plus_reg      <= '0;
                y_minus_reg     <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_valid = point_valid_reg;
    assign point_last  = point_last_reg;
    assign x_plus      = x_plus_reg;
    assign x_minus     = x_minus_reg;
    assign y_plus      = y_plus_reg;
    assign y_minus     = y_minus_reg;

`include "midpoint_ellipse_generator_assert.svh"

    `MEG_ASSERT_NOW(a_emit_slot_free, cmd.emit, out_free, "emit into occupied output register")
    `MEG_ASSERT_NEXT(a_emit_sets_valid, cmd.emit, out_valid_reg, "emitted request not presented")
    `MEG_ASSERT_NOW(a_done_below_axis, phase_reg == PH_DONE, offset_y_reg[OFS_W-1],
                    "trace finished with non-negative y offset")

endmodule

// ===== rtl/meg_ctrl.sv =====
// ----------------------------------------------------------------------------
// meg_ctrl
// Sequencer of the ellipse generator: accepts input requests, schedules the
// shared multiplier for trace setup and region change, and issues emits.
// ----------------------------------------------------------------------------
module meg_ctrl
    import meg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        restart,
    input  meg_status_t sts,
    output meg_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_R0,
        S_R1,
        S_R2,
        S_R3,
        S_EMIT,
        S_T0,
        S_T1,
        S_T2,
        S_T3,
        S_T4,
        S_T5
    } state_t;

    state_t state_reg;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd = '0;
        cmd.mul_sel = MUL_RXRX;
        case (state_reg)
            S_IDLE: cmd.latch_cfg = accept && restart;
            S_R0:   cmd.mul_sel = MUL_RXRX;
            S_R1:
            begin
                cmd.load_rx2 = 1'b1;
                cmd.mul_sel  = MUL_RYRY;
            end
            S_R2:
            begin
                cmd.load_ry2 = 1'b1;
                cmd.mul_sel  = MUL_RX2RY;
            end
            S_R3:   cmd.init_trace = 1'b1;
            S_EMIT: cmd.emit = sts.out_free;
            S_T0:   cmd.mul_sel = MUL_TT;
            S_T1:
            begin
                cmd.load_tmp = 1'b1;
                cmd.mul_sel  = MUL_YY;
            end
            S_T2:
            begin
                cmd.load_tmp = 1'b1;
                cmd.mul_sel  = MUL_RY2TMP;
            end
            S_T3:
            begin
                cmd.dec_load = 1'b1;
                cmd.mul_sel  = MUL_RX2TMP;
            end
            S_T4:
            begin
                cmd.dec_add = 1'b1;
                cmd.mul_sel = MUL_RX2RY2;
            end
            S_T5:   cmd.dec_sub = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= restart ? S_R0 : S_EMIT;
                    end
                end
                S_R0: state_reg <= S_R1;
                S_R1: state_reg <= S_R2;
                S_R2: state_reg <= S_R3;
                S_R3: state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= sts.trans ? S_T0 : S_IDLE;
                    end
                end
                S_T0: state_reg <= S_T1;
                S_T1: state_reg <= S_T2;
                S_T2: state_reg <= S_T3;
                S_T3: state_reg <= S_T4;
                S_T4: state_reg <= S_T5;
                S_T5: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`include "midpoint_ellipse_generator_assert.svh"

    `MEG_ASSERT_NEXT(a_restart_setup, accept && restart, state_reg == S_R0,
                     "restart request did not start setup")
    `MEG_ASSERT_NEXT(a_advance_emit, accept && !restart, state_reg == S_EMIT,
                     "advance request did not go to emit")
    `MEG_ASSERT_NEXT(a_emit_holds, (state_reg == S_EMIT) && !sts.out_free,
                     state_reg == S_EMIT, "emit left while output busy")

endmodule
